FILE: rtl/core/log_record_deframer_with_hash_top_assert.svh
// Assertion macro used by the checker file rldh_checker.sv.
`ifndef LOG_RECORD_DEFRAMER_WITH_HASH_TOP_ASSERT_SVH
`define LOG_RECORD_DEFRAMER_WITH_HASH_TOP_ASSERT_SVH

// Concurrent check, disabled while reset is asserted.
`define RLDH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: rtl/core/rldh_pkg.sv
package rldh_pkg;

  localparam int unsigned PayloadLimitDef = 65536;
  localparam int unsigned CfgW = 17;
  localparam int unsigned AddrW = 3;
  localparam int unsigned LeftW = 17;
  localparam int unsigned OutDataW = 232;

  // register index carried by paddr[2]
  localparam logic CfgIdxMaxLen = 1'b0;

  localparam logic CmdByte = 1'b0;
  localparam logic CmdEnd = 1'b1;

  typedef enum logic [1:0] {
    KindRecord  = 2'd0,
    KindReject  = 2'd1,
    KindSummary = 2'd2
  } kind_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] txn_id;
    logic [31:0] commit_value;
    logic [31:0] payload_len;
    logic [31:0] payload_hash;
    logic [31:0] recovered_count;
    logic [31:0] skipped_count;
    logic [31:0] bytes_read;
    logic        corruption_seen;
  } result_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

FILE: rtl/core/rldh_cfg.sv
module rldh_cfg #(
  parameter int unsigned PayloadLimit = rldh_pkg::PayloadLimitDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rldh_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [31:0]               limit_o
);
  import rldh_pkg::*;

  function automatic logic [31:0] eff_limit(input logic [CfgW-1:0] v);
    logic [31:0] w;
    w = {{(32-CfgW){1'b0}}, v};
    return (w < 32'(PayloadLimit)) ? w : 32'(PayloadLimit);
  endfunction

  localparam logic [CfgW-1:0] MaxLenRst = CfgW'(PayloadLimit);
  localparam logic [31:0] LimitRst = eff_limit(MaxLenRst);

  logic [CfgW-1:0] max_len_q, max_len_d;
  logic [31:0]     limit_q, limit_d;
  logic            wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite & (paddr[2] == CfgIdxMaxLen);

  always_comb begin
    max_len_d = wr ? pwdata[CfgW-1:0] : max_len_q;
    limit_d   = wr ? eff_limit(pwdata[CfgW-1:0]) : limit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenRst;
      limit_q   <= LimitRst;
    end else begin
      max_len_q <= max_len_d;
      limit_q   <= limit_d;
    end
  end

  assign prdata  = (paddr[2] == CfgIdxMaxLen) ? {{(32-CfgW){1'b0}}, max_len_q} : 32'd0;
  assign limit_o = limit_q;

endmodule

FILE: rtl/core/rldh_in_stage.sv
module rldh_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  rldh_pkg::in_item_t item_i,
  input  logic               take_i,
  output logic               valid_o,
  output rldh_pkg::in_item_t item_o
);
  import rldh_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // accept while empty or while the held item moves on
  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/core/rldh_core.sv
module rldh_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rldh_pkg::in_item_t item_i,
  output logic               take_o,
  input  logic [31:0]        limit_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rldh_pkg::result_t  out_o
);
  import rldh_pkg::*;

  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[{lane, 3'b000} +: 8] = b;
    return r;
  endfunction

  logic             in_payload_q, in_payload_d;
  logic [3:0]       hdr_idx_q, hdr_idx_d;
  logic [31:0]      txn_q, txn_d;
  logic [31:0]      commit_q, commit_d;
  logic [31:0]      len_q, len_d;
  logic [LeftW-1:0] left_q, left_d;
  logic [31:0]      hash_q, hash_d;
  logic [31:0]      ok_q, ok_d;
  logic [31:0]      bad_q, bad_d;
  logic [31:0]      bytes_q, bytes_d;
  logic             dmg_q, dmg_d;

  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;
  logic    fire, emit;

  assign fire   = valid_i && (!out_valid_q || out_ready_i);
  assign take_o = fire;

  always_comb begin
    in_payload_d = in_payload_q;
    hdr_idx_d    = hdr_idx_q;
    txn_d        = txn_q;
    commit_d     = commit_q;
    len_d        = len_q;
    left_d       = left_q;
    hash_d       = hash_q;
    ok_d         = ok_q;
    bad_d        = bad_q;
    bytes_d      = bytes_q;
    dmg_d        = dmg_q;
    emit         = 1'b0;
    res_d        = '0;
    res_d.kind   = KindRecord;

    if (fire) begin
      if (item_i.cmd == CmdEnd) begin
        // a log cut past the first header word or inside a payload is skipped
        if (in_payload_q || (hdr_idx_q[3:2] != 2'd0)) begin
          bad_d = sat_add32(bad_q, 32'd1);
          dmg_d = 1'b1;
        end
        emit                  = 1'b1;
        res_d.kind            = KindSummary;
        res_d.recovered_count = ok_q;
        res_d.skipped_count   = bad_d;
        res_d.bytes_read      = bytes_q;
        res_d.corruption_seen = dmg_d;
        in_payload_d = 1'b0;
        hdr_idx_d    = 4'd0;
        txn_d        = '0;
        commit_d     = '0;
        len_d        = '0;
        left_d       = '0;
        hash_d       = '0;
        ok_d         = '0;
        bad_d        = '0;
        bytes_d      = '0;
        dmg_d        = 1'b0;
      end else if (in_payload_q) begin
        hash_d = ({hash_q[26:0], 5'b00000} + hash_q) ^ {24'd0, item_i.data};
        left_d = left_q - LeftW'(1);
        if (left_q == LeftW'(1)) begin
          in_payload_d          = 1'b0;
          bytes_d               = sat_add32(bytes_q, len_q);
          ok_d                  = sat_add32(ok_q, 32'd1);
          emit                  = 1'b1;
          res_d.kind            = KindRecord;
          res_d.txn_id          = txn_q;
          res_d.commit_value    = commit_q;
          res_d.payload_len     = len_q;
          res_d.payload_hash    = hash_d;
          res_d.recovered_count = ok_d;
          res_d.skipped_count   = bad_q;
          res_d.bytes_read      = bytes_d;
          res_d.corruption_seen = dmg_q;
        end
      end else begin
        case (hdr_idx_q[3:2])
          2'd0:    txn_d    = put_byte(txn_q, hdr_idx_q[1:0], item_i.data);
          2'd1:    commit_d = put_byte(commit_q, hdr_idx_q[1:0], item_i.data);
          default: len_d    = put_byte(len_q, hdr_idx_q[1:0], item_i.data);
        endcase
        hdr_idx_d = hdr_idx_q + 4'd1;
        if (hdr_idx_q[1:0] == 2'd3) begin
          bytes_d = sat_add32(bytes_q, 32'd4);
        end
        if (hdr_idx_q == 4'd11) begin
          hdr_idx_d             = 4'd0;
          hash_d                = '0;
          res_d.txn_id          = txn_d;
          res_d.commit_value    = commit_d;
          res_d.payload_len     = len_d;
          res_d.bytes_read      = bytes_d;
          if (len_d > limit_i) begin
            bad_d                 = sat_add32(bad_q, 32'd1);
            dmg_d                 = 1'b1;
            emit                  = 1'b1;
            res_d.kind            = KindReject;
            res_d.recovered_count = ok_q;
            res_d.skipped_count   = bad_d;
            res_d.corruption_seen = 1'b1;
          end else if (len_d == 32'd0) begin
            ok_d                  = sat_add32(ok_q, 32'd1);
            emit                  = 1'b1;
            res_d.kind            = KindRecord;
            res_d.recovered_count = ok_d;
            res_d.skipped_count   = bad_q;
            res_d.corruption_seen = dmg_q;
          end else begin
            // limit stays below 2^17, so the length fits the down counter
            left_d       = len_d[LeftW-1:0];
            in_payload_d = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      hdr_idx_q    <= 4'd0;
      txn_q        <= '0;
      commit_q     <= '0;
      len_q        <= '0;
      left_q       <= '0;
      hash_q       <= '0;
      ok_q         <= '0;
      bad_q        <= '0;
      bytes_q      <= '0;
      dmg_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      in_payload_q <= in_payload_d;
      hdr_idx_q    <= hdr_idx_d;
      txn_q        <= txn_d;
      commit_q     <= commit_d;
      len_q        <= len_d;
      left_q       <= left_d;
      hash_q       <= hash_d;
      ok_q         <= ok_d;
      bad_q        <= bad_d;
      bytes_q      <= bytes_d;
      dmg_q        <= dmg_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

endmodule

FILE: rtl/core/log_record_deframer_with_hash_top.sv
// An item is registered on entry and its result, if any, is registered when the core
// takes the item; the core waits while a held result is not yet accepted.
// Throughput: one byte per cycle, parsed and hashed as it is taken, while no held result stalls.
// Reset (rst_ni low, asynchronous): empties both stages, clears the parse state
// and counters, and sets max_payload_len to PayloadLimit.
module log_record_deframer_with_hash_top #(
  parameter int unsigned PayloadLimit = rldh_pkg::PayloadLimitDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] data_byte
  input  logic                       s_axis_tuser,  // [0] cmd
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [31:0] txn_id, [63:32] commit_value, [95:64] payload_len, [127:96] payload_hash,
  // [159:128] recovered_count, [191:160] skipped_count, [223:192] bytes_read,
  // [224] corruption_seen, [231:225] zero
  output logic [rldh_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [1:0]                 m_axis_tuser,  // [1:0] kind
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rldh_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import rldh_pkg::*;

  in_item_t s_item, core_item;
  logic     core_valid, core_take;
  logic [31:0] limit;
  result_t  res;

  assign s_item.cmd  = s_axis_tuser;
  assign s_item.data = s_axis_tdata;

  rldh_cfg #(
    .PayloadLimit(PayloadLimit)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  rldh_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (s_item),
    .take_i  (core_take),
    .valid_o (core_valid),
    .item_o  (core_item)
  );

  rldh_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (core_valid),
    .item_i      (core_item),
    .take_o      (core_take),
    .limit_i     (limit),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {7'd0, res.corruption_seen, res.bytes_read, res.skipped_count,
                         res.recovered_count, res.payload_hash, res.payload_len,
                         res.commit_value, res.txn_id};

endmodule

FILE: rtl/core/rldh_checker.sv
`include "log_record_deframer_with_hash_top_assert.svh"

module rldh_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [231:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);
  import rldh_pkg::*;

  `RLDH_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `RLDH_ASSERT(a_in_stall, clk_i, rst_ni, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without a held result")
  `RLDH_ASSERT(a_summary_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == KindSummary |-> m_axis_tdata[127:0] == 128'd0, "summary carries header fields")
  `RLDH_ASSERT(a_reject_flags, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == KindReject |-> m_axis_tdata[127:96] == 32'd0 && m_axis_tdata[224] && m_axis_tdata[191:160] != 32'd0, "reject without hash clear or skip count")

endmodule

bind log_record_deframer_with_hash_top rldh_checker u_rldh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/log_deframe_checker.sv
module log_deframe_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tuser,   // [0] cmd
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] txn_id, [63:32] commit_value, [95:64] payload_len, [127:96] payload_hash,
  // [159:128] recovered_count, [191:160] skipped_count, [223:192] bytes_read,
  // [224] corruption_seen, [231:225] zero
  input  logic [rldh_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic [1:0]                    m_axis_tuser,   // [1:0] kind
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rldh_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  output int                            backlog_o,
  output int                            errors_o,
  output int                            checked_o
);
  import rldh_pkg::*;

  logic [16:0] len_limit;
  logic        in_body;
  logic [3:0]  hdr_idx;
  logic [31:0] hdr_txn;
  logic [31:0] hdr_commit;
  logic [31:0] hdr_len;
  logic [16:0] body_left;
  logic [31:0] body_hash;
  logic [31:0] n_ok;
  logic [31:0] n_bad;
  logic [31:0] n_bytes;
  logic        damaged;

  result_t due_results[$];
  int      mismatches = 0;
  int      results_seen = 0;

  function automatic logic [31:0] sat_plus(input logic [31:0] a, input logic [31:0] b);
    return (a > 32'hFFFF_FFFF - b) ? 32'hFFFF_FFFF : a + b;
  endfunction

  task automatic restart_log();
    in_body    = 1'b0;
    hdr_idx    = '0;
    hdr_txn    = '0;
    hdr_commit = '0;
    hdr_len    = '0;
    body_left  = '0;
    body_hash  = '0;
    n_ok       = '0;
    n_bad      = '0;
    n_bytes    = '0;
    damaged    = 1'b0;
  endtask

  task automatic post(input kind_e k, input logic [31:0] txn, input logic [31:0] commit,
                      input logic [31:0] len, input logic [31:0] hash);
    result_t r;
    r.kind            = k;
    r.txn_id          = txn;
    r.commit_value    = commit;
    r.payload_len     = len;
    r.payload_hash    = hash;
    r.recovered_count = n_ok;
    r.skipped_count   = n_bad;
    r.bytes_read      = n_bytes;
    r.corruption_seen = damaged;
    due_results.insert(due_results.size(), r);
  endtask

  task automatic parse_log_byte(input logic cmd, input logic [7:0] b);
    logic [3:0]  nxt;
    logic [31:0] cap;
    cap = {15'd0, len_limit};
    if (cap > PayloadLimitDef) cap = PayloadLimitDef;
    if (cmd == CmdEnd) begin
      // a log cut past the first header word or inside a payload loses that record
      if (in_body || hdr_idx >= 4'd4) begin
        n_bad   = sat_plus(n_bad, 32'd1);
        damaged = 1'b1;
      end
      post(KindSummary, '0, '0, '0, '0);
      restart_log();
    end else if (in_body) begin
      body_hash = ((body_hash << 5) + body_hash) ^ {24'd0, b};
      body_left = body_left - 17'd1;
      if (body_left == '0) begin
        in_body = 1'b0;
        n_bytes = sat_plus(n_bytes, hdr_len);
        n_ok    = sat_plus(n_ok, 32'd1);
        post(KindRecord, hdr_txn, hdr_commit, hdr_len, body_hash);
      end
    end else begin
      case (hdr_idx[3:2])
        2'd0:    hdr_txn[{hdr_idx[1:0], 3'b000} +: 8] = b;
        2'd1:    hdr_commit[{hdr_idx[1:0], 3'b000} +: 8] = b;
        default: hdr_len[{hdr_idx[1:0], 3'b000} +: 8] = b;
      endcase
      nxt = hdr_idx + 4'd1;
      if (nxt[1:0] == 2'd0) n_bytes = sat_plus(n_bytes, 32'd4);
      if (nxt < 4'd12) begin
        hdr_idx = nxt;
      end else begin
        hdr_idx   = '0;
        body_hash = '0;
        if (hdr_len > cap) begin
          // resync: the next byte opens a new header
          n_bad   = sat_plus(n_bad, 32'd1);
          damaged = 1'b1;
          post(KindReject, hdr_txn, hdr_commit, hdr_len, '0);
        end else if (hdr_len == '0) begin
          n_ok = sat_plus(n_ok, 32'd1);
          post(KindRecord, hdr_txn, hdr_commit, '0, '0);
        end else begin
          body_left = hdr_len[16:0];
          in_body   = 1'b1;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] result %0d: %s is %h, predicted %h", $realtime, results_seen, what,
             got, want);
    mismatches++;
  endtask

  task automatic compare_result();
    result_t want;
    results_seen++;
    if (due_results.size() == 0) begin
      report_mismatch("unpredicted result, kind", {30'd0, m_axis_tuser}, '0);
    end else begin
      want = due_results.pop_front();
      if (m_axis_tuser !== want.kind)
        report_mismatch("kind", {30'd0, m_axis_tuser}, {30'd0, want.kind});
      if (m_axis_tdata[31:0] !== want.txn_id)
        report_mismatch("txn_id", m_axis_tdata[31:0], want.txn_id);
      if (m_axis_tdata[63:32] !== want.commit_value)
        report_mismatch("commit_value", m_axis_tdata[63:32], want.commit_value);
      if (m_axis_tdata[95:64] !== want.payload_len)
        report_mismatch("payload_len", m_axis_tdata[95:64], want.payload_len);
      if (m_axis_tdata[127:96] !== want.payload_hash)
        report_mismatch("payload_hash", m_axis_tdata[127:96], want.payload_hash);
      if (m_axis_tdata[159:128] !== want.recovered_count)
        report_mismatch("recovered_count", m_axis_tdata[159:128], want.recovered_count);
      if (m_axis_tdata[191:160] !== want.skipped_count)
        report_mismatch("skipped_count", m_axis_tdata[191:160], want.skipped_count);
      if (m_axis_tdata[223:192] !== want.bytes_read)
        report_mismatch("bytes_read", m_axis_tdata[223:192], want.bytes_read);
      if (m_axis_tdata[224] !== want.corruption_seen)
        report_mismatch("corruption_seen", {31'd0, m_axis_tdata[224]},
                        {31'd0, want.corruption_seen});
      if (m_axis_tdata[231:225] !== '0)
        report_mismatch("padding", {25'd0, m_axis_tdata[231:225]}, '0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_limit = 17'(PayloadLimitDef);
      restart_log();
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == CfgIdxMaxLen)
        len_limit = pwdata[16:0];
      if (s_axis_tvalid && s_axis_tready) parse_log_byte(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) compare_result();
    end
    backlog_o <= due_results.size();
    errors_o  <= mismatches;
    checked_o <= results_seen;
  end

endmodule

FILE: tb/log_record_deframer_with_hash_top_test.sv
module log_record_deframer_with_hash_top_test;
  import rldh_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [7:0] data_byte
  logic                s_axis_tuser = CmdByte;  // [0] cmd
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [31:0] txn_id, [63:32] commit_value, [95:64] payload_len, [127:96] payload_hash,
  // [159:128] recovered_count, [191:160] skipped_count, [223:192] bytes_read,
  // [224] corruption_seen, [231:225] zero
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;        // [1:0] kind
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  logic        quiet = 1'b0;
  logic [31:0] eff_limit = PayloadLimitDef;
  int          backlog;
  int          errors;
  int          checked;
  int          log_items = 0;
  int          limit_settings = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  log_record_deframer_with_hash_top uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  log_deframe_checker deframe_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .backlog_o(backlog), .errors_o(errors), .checked_o(checked)
  );

  always @(posedge clk_i) m_axis_tready <= quiet || ($urandom_range(0, 99) >= 14);

  // leaves tvalid high after the handshake so back-to-back items need no toggle
  task automatic send_item(input logic cmd, input logic [7:0] b);
    while (!quiet && $urandom_range(0, 99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    log_items++;
  endtask

  task automatic send_header(input logic [31:0] txn, input logic [31:0] commit,
                             input logic [31:0] len);
    logic [95:0] hdr;
    hdr = {len, commit, txn};
    for (int i = 0; i < 12; i++) send_item(CmdByte, hdr[8*i +: 8]);
  endtask

  task automatic send_payload(input int n);
    repeat (n) send_item(CmdByte, 8'($urandom));
  endtask

  // hold the sender until every predicted result is out and the pipeline is empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [31:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {CfgIdxMaxLen, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    eff_limit = {15'd0, value[16:0]};
    if (eff_limit > PayloadLimitDef) eff_limit = PayloadLimitDef;
    limit_settings++;
  endtask

  task automatic random_traffic(input int quota);
    int          stop_at;
    int          pick;
    int          cap;
    int          cut;
    logic [31:0] len;
    logic [95:0] hdr;
    stop_at = log_items + quota;
    while (log_items < stop_at) begin
      pick = $urandom_range(0, 99);
      cap  = (eff_limit > 24) ? 24 : int'(eff_limit);
      if (pick < 65) begin
        case ($urandom_range(0, 9))
          7:       len = (eff_limit <= 40) ? eff_limit : 32'($urandom_range(0, cap));
          8:       len = eff_limit + 32'd1;
          9:       len = $urandom | 32'h0002_0000;
          default: len = $urandom_range(0, cap);
        endcase
        send_header($urandom, $urandom, len);
        if (len <= eff_limit) send_payload(int'(len));
      end else if (pick < 75) begin
        send_item(CmdEnd, 8'($urandom));
      end else if (pick < 87) begin
        // cut a record short anywhere in its header or payload
        len = $urandom_range(1, (cap == 0) ? 1 : cap);
        hdr = {len, 32'($urandom), 32'($urandom)};
        cut = $urandom_range(0, 11 + int'(len));
        for (int i = 0; i < cut; i++) begin
          if (i < 12) send_item(CmdByte, hdr[8*i +: 8]);
          else send_item(CmdByte, 8'($urandom));
        end
        send_item(CmdEnd, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 5)) send_item(CmdByte, 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [31:0] limit_plan [6];
    limit_plan = '{32'd0, 32'd1, 32'd16, 32'($urandom_range(3, 40)), 32'd2, 32'hFFFF_FFFF};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_limit(32'd65536);
    send_item(CmdEnd, 8'hFF);
    send_header(32'hFFFF_FFFF, 32'h0000_0000, 32'd0);
    send_item(CmdByte, 8'h00);
    send_item(CmdByte, 8'hFF);
    send_item(CmdByte, 8'h5A);
    send_item(CmdEnd, 8'h00);
    send_payload(6);
    send_item(CmdEnd, 8'hA5);
    random_traffic(115);

    foreach (limit_plan[k]) begin
      set_limit(limit_plan[k]);
      quiet <= (limit_plan[k] == 32'd16);
      random_traffic(115);
    end
    quiet <= 1'b0;

    // largest length the block takes, cut short by end of log, then one past it
    send_header($urandom, $urandom, 32'd65536);
    send_payload(5);
    send_item(CmdEnd, 8'h00);
    send_header($urandom, $urandom, 32'd65537);
    send_item(CmdEnd, 8'h00);
    drain();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d log items under %0d length limits, ragged log ends included;",
             log_items, limit_settings);
    $display("compared %0d deframed results field by field.", checked);
    if (errors == 0 && backlog == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rldh_pkg.sv
rtl/core/rldh_cfg.sv
rtl/core/rldh_in_stage.sv
rtl/core/rldh_core.sv
rtl/core/log_record_deframer_with_hash_top.sv
rtl/core/rldh_checker.sv
tb/log_deframe_checker.sv
tb/log_record_deframer_with_hash_top_test.sv
